@@ src/xkv_pkg.sv @@
// Shared types and constants for the keyed varint byte-stream encoder.
// No dependencies; used by xkv_key and xor_keyed_varint_encoder_top.

package xkv_pkg;

  // Number of key bytes in one cycle of the stream position (1..8).
  localparam int unsigned KEY_LENGTH = 7;

  localparam int unsigned POS_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned GRP_W  = 7;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_RAW     = 2'd1,
    MODE_VARINT  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // Position control from the sequencer to the key unit.
  typedef struct packed {
    logic restart;
    logic advance;
  } key_ctl_t;

  // Key byte at a stream position; a position past the seventh byte reads 0.
  function automatic byte_t key_byte(input pos_t pos);
    byte_t k;
    unique case (pos)
      3'd0:    k = 8'h43;
      3'd1:    k = 8'h37;
      3'd2:    k = 8'h92;
      3'd3:    k = 8'ha4;
      3'd4:    k = 8'h38;
      3'd5:    k = 8'hf1;
      3'd6:    k = 8'h2b;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

@@ src/xkv_key.sv @@
// Stream position counter and key byte lookup.
// Depends on xkv_pkg.

module xkv_key (
  input  logic              clk,
  input  logic              rst_n,
  input  xkv_pkg::key_ctl_t ctl,
  output xkv_pkg::byte_t    key
);

  xkv_pkg::pos_t pos_r;
  xkv_pkg::pos_t pos_nxt;
  logic [xkv_pkg::POS_W:0] pos_inc;

  assign pos_inc = {1'b0, pos_r} + {{xkv_pkg::POS_W{1'b0}}, 1'b1};

  always_comb begin
    pos_nxt = pos_r;
    priority if (ctl.restart) begin
      pos_nxt = '0;
    end else if (ctl.advance) begin
      // wrap after the last key byte
      if (pos_inc >= (xkv_pkg::POS_W + 1)'(xkv_pkg::KEY_LENGTH)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[xkv_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign key = xkv_pkg::key_byte(pos_r);

endmodule

@@ src/xor_keyed_varint_encoder_top.sv @@
// Keyed LEB128 varint byte-stream encoder, top level.
// Depends on xkv_pkg and xkv_key.
//
//   channel  | direction | tdata            | tuser      | tlast
//   ---------+-----------+------------------+------------+---------------------
//   in_      | slave     | [31:0] value     | [1:0] mode | -
//   out_     | master    | [7:0] out_byte   | -          | last byte of an item
//
// Flow: the first byte of an item stands in the output register the cycle
// after the item is taken. Each further byte follows the transfer of the one
// before. Restart and the unused mode emit nothing and leave the block ready
// for the next item. One 7-bit group shifter forms every varint byte, one per
// cycle while out_tready is high, from the input or from the held remainder;
// raw bytes come straight from the input. This shared unit sets the rate.
// Reset: synchronous, active low; clears the sequencer and the key position.
// Stalls: in_tready is low while bytes of an item are pending; a low
// out_tready holds the current byte and the remainder.

module xor_keyed_varint_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast   // last
);

  xkv_pkg::state_t   state_r, state_nxt;
  xkv_pkg::val_t     val_r, val_nxt;      // remaining varint bits
  xkv_pkg::byte_t    byte_r, byte_nxt;    // keyed byte on the output
  logic              last_r, last_nxt;
  xkv_pkg::key_ctl_t key_ctl;
  xkv_pkg::byte_t    key;

  logic              in_xfer, out_xfer;
  xkv_pkg::mode_t    mode;

  // shared group unit
  xkv_pkg::val_t     grp_src;
  logic              grp_more;
  xkv_pkg::byte_t    grp_byte;

  assign in_tready  = state_r[1'b0] ? (state_r == xkv_pkg::ST_IDLE) : 1'b0;
  assign out_tvalid = (state_r == xkv_pkg::ST_EMIT);
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign mode     = xkv_pkg::mode_t'(in_tuser);

  // Next 7-bit group with its continuation bit.
  assign grp_src  = (state_r == xkv_pkg::ST_IDLE) ? in_tdata : val_r;
  assign grp_more = |grp_src[xkv_pkg::VAL_W-1:xkv_pkg::GRP_W];
  assign grp_byte = {grp_more, grp_src[xkv_pkg::GRP_W-1:0]};

  xkv_key u_key (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (key_ctl),
    .key   (key)
  );

  always_comb begin
    state_nxt       = state_r;
    val_nxt         = val_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    key_ctl.restart = 1'b0;
    key_ctl.advance = 1'b0;

    unique case (state_r)
      xkv_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (mode)
            xkv_pkg::MODE_RESTART: begin
              key_ctl.restart = 1'b1;
            end
            xkv_pkg::MODE_RAW: begin
              byte_nxt        = in_tdata[xkv_pkg::BYTE_W-1:0] ^ key;
              last_nxt        = 1'b1;
              key_ctl.advance = 1'b1;
              state_nxt       = xkv_pkg::ST_EMIT;
            end
            xkv_pkg::MODE_VARINT: begin
              byte_nxt        = grp_byte ^ key;
              last_nxt        = !grp_more;
              val_nxt         = grp_src >> xkv_pkg::GRP_W;
              key_ctl.advance = 1'b1;
              state_nxt       = xkv_pkg::ST_EMIT;
            end
            xkv_pkg::MODE_NONE: begin
              // ignored
            end
            default: begin
            end
          endcase
        end
      end
      xkv_pkg::ST_EMIT: begin
        if (out_xfer) begin
          if (last_r) begin
            state_nxt = xkv_pkg::ST_IDLE;
          end else begin
            byte_nxt        = grp_byte ^ key;
            last_nxt        = !grp_more;
            val_nxt         = grp_src >> xkv_pkg::GRP_W;
            key_ctl.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = xkv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  // A non-final varint byte always leaves bits to send.
  a_more_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (val_r != '0))
    else $error("continuation byte with empty remainder");

  // Final byte transfer returns the block to ready.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> in_tready)
    else $error("not ready after final byte");

  // Restart and unused mode emit nothing.
  a_silent_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tuser == xkv_pkg::MODE_RESTART || in_tuser == xkv_pkg::MODE_NONE))
    |=> (in_tready && !out_tvalid))
    else $error("silent item produced output");

  // A small varint is a single final byte.
  a_short_varint: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == xkv_pkg::MODE_VARINT && in_tdata[31:7] == '0)
    |=> (out_tvalid && out_tlast))
    else $error("short varint not a single byte");

endmodule
